>>> sv/keyed_record_table_core_defines.svh
// assertion macros for the keyed record table
`ifndef KEYED_RECORD_TABLE_CORE_DEFINES_SVH
`define KEYED_RECORD_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define KRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("krt check failed");

// next-cycle implication
`define KRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("krt check failed");

`endif

>>> sv/krt_pkg.sv
`timescale 1ns / 1ps
package krt_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned POS_W    = 7;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_DEL  = 2'd1,
    MODE_FIND = 2'd2,
    MODE_LIST = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MISS  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name_low;
    logic [47:0]        name_high;
    logic [23:0]        branch;
    logic [63:0]        address_low;
    logic [7:0]         address_high;
  } record_t;

  typedef struct packed {
    mode_e   mode;
    record_t rec;
  } req_t;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [POS_W-1:0] position;
    logic             last;
    record_t          rec;
  } emit_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    record_t          wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

>>> sv/krt_req_if.sv
`timescale 1ns / 1ps
interface krt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] key;
  logic [63:0]        name_low;
  logic [47:0]        name_high;
  logic [23:0]        branch_code;
  logic [63:0]        address_low;
  logic [7:0]         address_high;

  modport source (
    output valid, mode, key, name_low, name_high, branch_code, address_low, address_high,
    input  ready
  );

  modport sink (
    input  valid, mode, key, name_low, name_high, branch_code, address_low, address_high,
    output ready
  );
endinterface

>>> sv/krt_rsp_if.sv
`timescale 1ns / 1ps
interface krt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [6:0]         position;
  logic signed [31:0] out_key;
  logic [63:0]        out_name_low;
  logic [47:0]        out_name_high;
  logic [23:0]        out_branch;
  logic [63:0]        out_address_low;
  logic [7:0]         out_address_high;
  logic               last;

  modport source (
    output valid, status, position, out_key, out_name_low, out_name_high, out_branch,
           out_address_low, out_address_high, last,
    input  ready
  );

  modport sink (
    input  valid, status, position, out_key, out_name_low, out_name_high, out_branch,
           out_address_low, out_address_high, last,
    output ready
  );
endinterface

>>> sv/krt_ram.sv
`timescale 1ns / 1ps
module krt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/krt_ctrl.sv
`timescale 1ns / 1ps
module krt_ctrl import krt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  req_t     req_i,
  input  logic     can_load_i,
  output emit_t    emit_o,
  output ram_req_t ram_o,
  input  record_t  rdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_HIT    = 3'd3;
  localparam logic [2:0] S_MISS   = 3'd4;
  localparam logic [2:0] S_DEL_WR = 3'd5;
  localparam logic [2:0] S_LIST   = 3'd6;
  localparam logic [2:0] S_EMPTY  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] data_idx_q, data_idx_d;
  logic             rd_pend_q, rd_pend_d;
  mode_e            mode_q, mode_d;
  record_t          rec_q, rec_d;

  logic             accept;
  logic             hit_now;
  logic             in_range;
  logic             at_last;
  logic [IDX_W-1:0] last_idx;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i & req_ready_o;
  assign last_idx    = IDX_W'(count_q - CNT_W'(1));
  assign in_range    = (rd_idx_q < count_q);
  assign at_last     = (data_idx_q == last_idx);
  assign hit_now     = (state_q == S_SEARCH) && rd_pend_q && (rdata_i.key == rec_q.key);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    data_idx_d = data_idx_q;
    rd_pend_d  = rd_pend_q;
    mode_d     = mode_q;
    rec_d      = rec_q;
    emit_o     = '0;
    ram_o      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rec_d     = req_i.rec;
          mode_d    = req_i.mode;
          rd_idx_d  = '0;
          rd_pend_d = 1'b0;
          unique case (req_i.mode) inside
            MODE_ADD: state_d = S_ADD;
            MODE_DEL, MODE_FIND: state_d = (count_q == '0) ? S_MISS : S_SEARCH;
            MODE_LIST: state_d = (count_q == '0) ? S_EMPTY : S_LIST;
          endcase
        end
      end
      S_ADD: begin
        if (can_load_i) begin
          emit_o.valid = 1'b1;
          emit_o.last  = 1'b1;
          if (count_q == CNT_W'(CAPACITY)) begin
            emit_o.status = ST_FULL;
          end else begin
            emit_o.status = ST_OK;
            emit_o.rec    = rec_q;
            ram_o.we      = 1'b1;
            ram_o.waddr   = count_q[IDX_W-1:0];
            ram_o.wdata   = rec_q;
            count_d       = count_q + CNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_SEARCH: begin
        ram_o.re    = in_range && !hit_now;
        ram_o.raddr = rd_idx_q[IDX_W-1:0];
        if (ram_o.re) begin
          rd_idx_d   = rd_idx_q + CNT_W'(1);
          data_idx_d = rd_idx_q[IDX_W-1:0];
        end
        rd_pend_d = ram_o.re || hit_now;
        if (hit_now) begin
          state_d = S_HIT;
        end else if (rd_pend_q && at_last) begin
          state_d = S_MISS;
        end
      end
      S_HIT: begin
        if (can_load_i) begin
          emit_o.valid  = 1'b1;
          emit_o.last   = 1'b1;
          emit_o.status = ST_OK;
          emit_o.rec    = rdata_i;
          rd_pend_d     = 1'b0;
          if (mode_q == MODE_DEL) begin
            ram_o.re    = 1'b1;
            ram_o.raddr = last_idx;
            state_d     = S_DEL_WR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DEL_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = data_idx_q;
        ram_o.wdata = rdata_i;
        count_d     = count_q - CNT_W'(1);
        state_d     = S_IDLE;
      end
      S_MISS: begin
        if (can_load_i) begin
          emit_o.valid  = 1'b1;
          emit_o.last   = 1'b1;
          emit_o.status = ST_MISS;
          state_d       = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (can_load_i) begin
          emit_o.valid  = 1'b1;
          emit_o.last   = 1'b1;
          emit_o.status = ST_EMPTY;
          state_d       = S_IDLE;
        end
      end
      S_LIST: begin
        ram_o.re    = in_range && (!rd_pend_q || can_load_i);
        ram_o.raddr = rd_idx_q[IDX_W-1:0];
        if (ram_o.re) begin
          rd_idx_d   = rd_idx_q + CNT_W'(1);
          data_idx_d = rd_idx_q[IDX_W-1:0];
        end
        rd_pend_d = ram_o.re || (rd_pend_q && !can_load_i);
        if (rd_pend_q && can_load_i) begin
          emit_o.valid    = 1'b1;
          emit_o.status   = ST_OK;
          emit_o.position = POS_W'(data_idx_q) + POS_W'(1);
          emit_o.last     = at_last;
          emit_o.rec      = rdata_i;
          if (at_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_idx_q <= data_idx_d;
    mode_q     <= mode_d;
    rec_q      <= rec_d;
  end

endmodule

>>> sv/keyed_record_table_core.sv
`timescale 1ns / 1ps
// keyed record table: unordered store of up to 64 records with a signed key
// req_i takes one command item (add, delete by key, lookup by key, list);
// the next command is taken only after the current one has put out its
// final result into the output register, which may still be waiting
// rsp_o gives one result per command, one per entry in a non-empty list;
// last marks the final result of a command
// steps from acceptance to the first result on rsp_o:
//   add, or a command that fails at once: emitted straight from its state
//   lookup or delete: one entry compared per cycle until a hit or the end
//   list: one entry per cycle while rsp_o is ready
// after its result, a delete moves the last entry into the freed slot
// the walk is bounded by the single read port of the record memory
// reset empties the table at once (the count goes to zero); no clearing pass
// when the receiver stalls, the result holds in the output register and the
// memory read data register holds the next entry until it can move on
`include "keyed_record_table_core_defines.svh"
module keyed_record_table_core import krt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  krt_req_if.sink      req_i,
  krt_rsp_if.source    rsp_o
);

  req_t     req;
  emit_t    emit;
  ram_req_t ram_req;
  record_t  rdata;
  logic [$bits(record_t)-1:0] rdata_raw;
  logic     can_load;
  logic     req_ready;
  logic     out_valid_q, out_valid_d;
  emit_t    out_q;

  assign req.mode             = mode_e'(req_i.mode);
  assign req.rec.key          = req_i.key;
  assign req.rec.name_low     = req_i.name_low;
  assign req.rec.name_high    = req_i.name_high;
  assign req.rec.branch       = req_i.branch_code;
  assign req.rec.address_low  = req_i.address_low;
  assign req.rec.address_high = req_i.address_high;
  assign req_i.ready          = req_ready;

  assign can_load = !out_valid_q || rsp_o.ready;
  assign rdata    = record_t'(rdata_raw);

  krt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .can_load_i  (can_load),
    .emit_o      (emit),
    .ram_o       (ram_req),
    .rdata_i     (rdata)
  );

  krt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(record_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata_raw)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.valid) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_q <= emit;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_q.status;
  assign rsp_o.position         = out_q.position;
  assign rsp_o.out_key          = out_q.rec.key;
  assign rsp_o.out_name_low     = out_q.rec.name_low;
  assign rsp_o.out_name_high    = out_q.rec.name_high;
  assign rsp_o.out_branch       = out_q.rec.branch;
  assign rsp_o.out_address_low  = out_q.rec.address_low;
  assign rsp_o.out_address_high = out_q.rec.address_high;
  assign rsp_o.last             = out_q.last;

  `KRT_ASSERT_IMPL(a_emit_has_slot, clk_i, rst_ni, emit.valid, can_load)
  `KRT_ASSERT_IMPL(a_ram_one_op, clk_i, rst_ni, ram_req.we, !ram_req.re)
  `KRT_ASSERT_IMPL(a_accept_quiet, clk_i, rst_ni, req_i.valid && req_ready, !emit.valid && !ram_req.we)
  `KRT_ASSERT_NEXT(a_emit_lands, clk_i, rst_ni, emit.valid, out_valid_q)

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import krt_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 470;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    logic             last;
    record_t          rec;
  } table_result_t;

  class record_table_ledger;
    record_t       entries[CAPACITY];
    int unsigned   count;
    table_result_t pending[$];
    int unsigned   errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void push_result(status_e status, int unsigned position, bit last, record_t rec);
      table_result_t r;
      r.status   = status;
      r.position = POS_W'(position);
      r.last     = last;
      r.rec      = rec;
      pending.push_back(r);
    endfunction

    function int find_first(logic [31:0] key);
      for (int j = 0; j < count; j++) begin
        if (entries[j].key == key) return j;
      end
      return -1;
    endfunction

    // accepted command item: update the table copy and queue its results
    function void apply_command(mode_e mode, record_t rec);
      int slot;
      case (mode)
        MODE_ADD: begin
          if (count >= CAPACITY) begin
            push_result(ST_FULL, 0, 1'b1, '0);
          end else begin
            entries[count] = rec;
            count++;
            push_result(ST_OK, 0, 1'b1, rec);
          end
        end
        MODE_DEL, MODE_FIND: begin
          slot = find_first(rec.key);
          if (slot < 0) begin
            push_result(ST_MISS, 0, 1'b1, '0);
          end else begin
            push_result(ST_OK, 0, 1'b1, entries[slot]);
            if (mode == MODE_DEL) begin
              // last entry fills the freed slot
              entries[slot] = entries[count-1];
              count--;
            end
          end
        end
        default: begin
          if (count == 0) begin
            push_result(ST_EMPTY, 0, 1'b1, '0);
          end else begin
            for (int j = 0; j < count; j++)
              push_result(ST_OK, j + 1, (j + 1 == count), entries[j]);
          end
        end
      endcase
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s expected %h got %h", $time, field, want, got);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none got status %0d key %h",
                 $time, got.status, got.rec.key);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.position !== want.position) report("position", want.position, got.position);
      if (got.rec.key !== want.rec.key) report("out_key", want.rec.key, got.rec.key);
      if (got.rec.name_low !== want.rec.name_low)
        report("out_name_low", want.rec.name_low, got.rec.name_low);
      if (got.rec.name_high !== want.rec.name_high)
        report("out_name_high", want.rec.name_high, got.rec.name_high);
      if (got.rec.branch !== want.rec.branch)
        report("out_branch", want.rec.branch, got.rec.branch);
      if (got.rec.address_low !== want.rec.address_low)
        report("out_address_low", want.rec.address_low, got.rec.address_low);
      if (got.rec.address_high !== want.rec.address_high)
        report("out_address_high", want.rec.address_high, got.rec.address_high);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;
  int unsigned idle_cycles = 0;
  record_table_ledger ledger;

  logic [31:0] key_pool[12] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                                32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0010,
                                32'h8000_0001, 32'h7fff_fffe, 32'h1234_5678, 32'hdead_beef};

  krt_req_if req();
  krt_rsp_if rsp();

  keyed_record_table_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic record_t make_record(logic [31:0] key, logic [63:0] pattern);
    record_t r;
    r.key          = key;
    r.name_low     = pattern;
    r.name_high    = pattern[47:0];
    r.branch       = pattern[23:0];
    r.address_low  = ~pattern;
    r.address_high = pattern[7:0];
    return r;
  endfunction

  function automatic record_t random_record();
    record_t     r;
    logic [63:0] w;
    logic [31:0] s;
    w = {$urandom, $urandom};
    r.name_low = w;
    w = {$urandom, $urandom};
    r.name_high = w[47:0];
    w = {$urandom, $urandom};
    r.address_low = w;
    s = $urandom;
    r.branch       = s[23:0];
    r.address_high = s[31:24];
    if ($urandom_range(0, 9) < 6) r.key = key_pool[$urandom_range(0, 11)];
    else r.key = $urandom;
    return r;
  endfunction

  task automatic send_command(mode_e mode, record_t rec);
    while (!calm && $urandom_range(0, 99) < 16) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid        = 1'b1;
    req.mode         = mode;
    req.key          = rec.key;
    req.name_low     = rec.name_low;
    req.name_high    = rec.name_high;
    req.branch_code  = rec.branch;
    req.address_low  = rec.address_low;
    req.address_high = rec.address_high;
    do @(posedge clk); while (req.ready !== 1'b1);
    ledger.apply_command(mode, rec);
    @(negedge clk);
  endtask

  task automatic send_keyed(mode_e mode, logic [31:0] key);
    record_t r;
    r     = random_record();
    r.key = key;
    send_command(mode, r);
  endtask

  always @(negedge clk) begin
    if (rst_n) rsp.ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin : result_monitor
    table_result_t seen;
    if (rst_n && rsp.valid && rsp.ready) begin
      seen.status           = status_e'(rsp.status);
      seen.position         = rsp.position;
      seen.last             = rsp.last;
      seen.rec.key          = rsp.out_key;
      seen.rec.name_low     = rsp.out_name_low;
      seen.rec.name_high    = rsp.out_name_high;
      seen.rec.branch       = rsp.out_branch;
      seen.rec.address_low  = rsp.out_address_low;
      seen.rec.address_high = rsp.out_address_high;
      ledger.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    record_t     rec;
    mode_e       mode;
    int unsigned pick;
    bit          filling;
    ledger           = new();
    rst_n            = 1'b0;
    req.valid        = 1'b0;
    req.mode         = MODE_ADD;
    req.key          = '0;
    req.name_low     = '0;
    req.name_high    = '0;
    req.branch_code  = '0;
    req.address_low  = '0;
    req.address_high = '0;
    rsp.ready        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table cases
    send_keyed(MODE_LIST, 32'h0);
    send_keyed(MODE_DEL, 32'h5);
    send_keyed(MODE_FIND, 32'h5);
    // field extremes and a duplicate key
    send_command(MODE_ADD, make_record(32'h8000_0000, 64'h0));
    send_command(MODE_ADD, make_record(32'h7fff_ffff, 64'hffff_ffff_ffff_ffff));
    send_command(MODE_ADD, make_record(32'h0000_0000, 64'h5555_5555_5555_5555));
    send_command(MODE_ADD, make_record(32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa));
    send_command(MODE_ADD, make_record(32'h0000_0000, 64'h0123_4567_89ab_cdef));
    send_keyed(MODE_LIST, 32'h0);
    send_keyed(MODE_FIND, 32'h0000_0000);
    send_keyed(MODE_FIND, 32'h7fff_ffff);
    send_keyed(MODE_FIND, 32'h0000_002a);
    // delete of a middle entry, then of the last one, then of the first
    send_keyed(MODE_DEL, 32'h0000_0000);
    send_keyed(MODE_FIND, 32'h0000_0000);
    send_keyed(MODE_DEL, 32'hffff_ffff);
    send_keyed(MODE_DEL, 32'h8000_0000);
    send_keyed(MODE_DEL, 32'h0000_004d);
    send_keyed(MODE_LIST, 32'h0);
    send_keyed(MODE_DEL, 32'h7fff_ffff);
    send_keyed(MODE_DEL, 32'h0000_0000);
    send_keyed(MODE_LIST, 32'h0);

    // fill and drain the table repeatedly with random content
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 180 && n < 260);
      if (ledger.count == CAPACITY) filling = 1'b0;
      else if (ledger.count == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      rec  = random_record();
      if (ledger.count == CAPACITY && pick < 40) mode = MODE_ADD;
      else if (pick < 8) mode = MODE_LIST;
      else if (pick < 20) mode = MODE_FIND;
      else if (filling) mode = (pick < 80) ? MODE_ADD : MODE_DEL;
      else mode = (pick < 75) ? MODE_DEL : MODE_ADD;
      if (mode != MODE_ADD && ledger.count > 0 && $urandom_range(0, 3) != 0)
        rec.key = ledger.entries[$urandom_range(0, ledger.count - 1)].key;
      send_command(mode, rec);
    end
    calm      = 1'b0;
    req.valid = 1'b0;

    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> keyed_record_table_core.f
+incdir+sv
sv/krt_pkg.sv
sv/krt_req_if.sv
sv/krt_rsp_if.sv
sv/krt_ram.sv
sv/krt_ctrl.sv
sv/keyed_record_table_core.sv
tb/sv/tb.sv
